/* hw/rtl/mst_pkg.sv */
`default_nettype none

package mst_pkg;

  // Table geometry.
  localparam int unsigned TimerSlots = 16;
  localparam int unsigned TickBits   = 16;
  localparam int unsigned MaxResults = 16;

  // Fixed field widths of the request and response channels.
  localparam int unsigned ReqW     = 2;
  localparam int unsigned TimeoutW = 16;
  localparam int unsigned TagW     = 8;
  localparam int unsigned SlotNumW = 4;
  localparam int unsigned StatusW  = 3;

  // Derived widths.
  localparam int unsigned SlotW  = $clog2(TimerSlots);
  localparam int unsigned CntW   = $clog2(MaxResults + 1);
  localparam int unsigned IdxCmpW = (SlotW > SlotNumW) ? SlotW : SlotNumW;
  localparam int unsigned ElCmpW  = (TickBits > TimeoutW) ? TickBits : TimeoutW;

  typedef enum logic [ReqW-1:0] {
    ReqAdd    = 2'd0,
    ReqDelete = 2'd1,
    ReqTick   = 2'd2
  } req_e;

  typedef enum logic [StatusW-1:0] {
    StatAdded    = 3'd0,
    StatFull     = 3'd1,
    StatDeleted  = 3'd2,
    StatNotFound = 3'd3,
    StatFired    = 3'd4,
    StatNone     = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StFinish
  } state_e;

  // One timer slot as it travels along the ring.
  typedef struct packed {
    logic                live;
    logic [TimeoutW-1:0] timeout;
    logic [TickBits-1:0] elapsed;
    logic                repeats;
    logic [TagW-1:0]     tag;
  } slot_t;

  // What the head update does to the slot passing by.
  typedef struct packed {
    logic do_add;
    logic do_del;
    logic do_tick;
  } proc_ctl_t;

  // What happened to the slot passing by.
  typedef struct packed {
    logic placed;
    logic deleted;
    logic fired;
  } proc_stat_t;

endpackage

`default_nettype wire

/* hw/rtl/mst_req_if.sv */
`default_nettype none

interface mst_req_if import mst_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ReqW-1:0]     req_type;
  logic [TimeoutW-1:0] timeout_ticks;
  logic                periodic;
  logic [TagW-1:0]     user_tag;
  logic [SlotNumW-1:0] target_slot;

  modport source (
    output valid, req_type, timeout_ticks, periodic, user_tag, target_slot,
    input  ready
  );

  modport sink (
    input  valid, req_type, timeout_ticks, periodic, user_tag, target_slot,
    output ready
  );
endinterface

`default_nettype wire

/* hw/rtl/mst_rsp_if.sv */
`default_nettype none

interface mst_rsp_if import mst_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [StatusW-1:0]  status;
  logic [SlotNumW-1:0] slot_number;
  logic [TagW-1:0]     fired_tag;
  logic                last_result;

  modport source (
    output valid, status, slot_number, fired_tag, last_result,
    input  ready
  );

  modport sink (
    input  valid, status, slot_number, fired_tag, last_result,
    output ready
  );
endinterface

`default_nettype wire

/* hw/rtl/mst_cell.sv */
`default_nettype none

// One storage cell of the slot ring. It takes its neighbor's slot on a shift.
module mst_cell import mst_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  shift_i,
  input  wire slot_t slot_i,
  output slot_t      slot_o
);

  logic  live_q;
  slot_t data_q;

  // The live bit is control state and is cleared by reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q <= 1'b0;
    end else if (shift_i) begin
      live_q <= slot_i.live;
    end
  end

  // The timer contents only matter while the slot is live.
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      data_q <= slot_i;
    end
  end

  always_comb begin
    slot_o      = data_q;
    slot_o.live = live_q;
  end

endmodule

`default_nettype wire

/* hw/rtl/mst_slot_proc.sv */
`default_nettype none

// Update applied to the slot at the head of the ring before it re-enters the tail.
module mst_slot_proc import mst_pkg::*; (
  input  wire proc_ctl_t ctl_i,
  input  wire slot_t     slot_i,
  input  wire slot_t     add_i,
  output slot_t          slot_o,
  output proc_stat_t     stat_o
);

  logic [TickBits-1:0] inc;

  // Saturating elapsed count.
  always_comb begin
    if (slot_i.elapsed == {TickBits{1'b1}}) begin
      inc = slot_i.elapsed;
    end else begin
      inc = slot_i.elapsed + TickBits'(1);
    end
  end

  always_comb begin
    slot_o = slot_i;
    stat_o = '0;
    // An add lands in the first free slot that passes.
    if (ctl_i.do_add && !slot_i.live) begin
      slot_o        = add_i;
      slot_o.live   = 1'b1;
      stat_o.placed = 1'b1;
    end
    // A delete frees the addressed slot if it is live.
    if (ctl_i.do_del && slot_i.live) begin
      slot_o.live    = 1'b0;
      stat_o.deleted = 1'b1;
    end
    // A tick advances the count and fires once the timeout is reached.
    if (ctl_i.do_tick && slot_i.live) begin
      slot_o.elapsed = inc;
      if (ElCmpW'(inc) >= ElCmpW'(slot_i.timeout)) begin
        stat_o.fired = 1'b1;
        if (slot_i.repeats) begin
          slot_o.elapsed = '0;
        end else begin
          slot_o.live = 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/multi_slot_software_timer.sv */
// Channel  Dir  Fields                                                      Transfer
// req_i    in   req_type, timeout_ticks, periodic, user_tag, target_slot    valid & ready
// rsp_o    out  status, slot_number, fired_tag, last_result                 valid & ready
//
// Each add, delete or tick rotates the slot ring once, one slot per cycle while the
// response side does not stall. The final response is registered after the scan, and the
// block takes no new request until that final response has been registered.
// The ring moves only when the response register is empty or being drained.
// Reset frees every slot; timer contents are undefined until an add writes them.
// A request type with no meaning is taken and dropped without any response.
`default_nettype none

module multi_slot_software_timer import mst_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  mst_req_if.sink   req_i,
  mst_rsp_if.source rsp_o
);

  state_e state_q, state_d;
  logic [SlotW-1:0] idx_q, idx_d;

  req_e                op_req_q;
  logic [TimeoutW-1:0] op_timeout_q;
  logic                op_periodic_q;
  logic [TagW-1:0]     op_tag_q;
  logic [SlotNumW-1:0] op_target_q;

  logic             add_pend_q, add_pend_d;
  logic             found_q, found_d;
  logic [SlotW-1:0] res_slot_q, res_slot_d;
  logic             hold_valid_q, hold_valid_d;
  logic [SlotW-1:0] hold_slot_q, hold_slot_d;
  logic [TagW-1:0]  hold_tag_q, hold_tag_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  logic                out_valid_q, out_valid_d;
  status_e             out_status_q, out_status_d;
  logic [SlotNumW-1:0] out_slot_q, out_slot_d;
  logic [TagW-1:0]     out_tag_q, out_tag_d;
  logic                out_last_q, out_last_d;

  logic       accept;
  logic       advance;
  logic       shift_en;
  proc_ctl_t  proc_ctl;
  proc_stat_t proc_stat;
  slot_t      add_rec;
  slot_t      tail_in;
  slot_t      ring [TimerSlots];

  assign req_i.ready = (state_q == StIdle);
  assign accept      = req_i.valid && req_i.ready;
  assign advance     = !out_valid_q || rsp_o.ready;
  assign shift_en    = (state_q == StScan) && advance;

  // Slot ring: cell i takes cell i+1, the last cell takes the updated head.
  for (genvar i = 0; i < TimerSlots; i++) begin : g_cell
    if (i == TimerSlots - 1) begin : g_tail
      mst_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (shift_en),
        .slot_i  (tail_in),
        .slot_o  (ring[i])
      );
    end else begin : g_body
      mst_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (shift_en),
        .slot_i  (ring[i+1]),
        .slot_o  (ring[i])
      );
    end
  end

  // Record written by an add.
  always_comb begin
    add_rec.live    = 1'b1;
    add_rec.timeout = op_timeout_q;
    add_rec.elapsed = '0;
    add_rec.repeats = op_periodic_q;
    add_rec.tag     = op_tag_q;
  end

  // Head update controls for the current request.
  always_comb begin
    proc_ctl.do_add  = (op_req_q == ReqAdd) && add_pend_q;
    proc_ctl.do_del  = (op_req_q == ReqDelete) &&
                       (IdxCmpW'(idx_q) == IdxCmpW'(op_target_q));
    proc_ctl.do_tick = (op_req_q == ReqTick);
  end

  mst_slot_proc u_proc (
    .ctl_i  (proc_ctl),
    .slot_i (ring[0]),
    .add_i  (add_rec),
    .slot_o (tail_in),
    .stat_o (proc_stat)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (accept && (req_e'(req_i.req_type) == ReqAdd ||
                       req_e'(req_i.req_type) == ReqDelete ||
                       req_e'(req_i.req_type) == ReqTick)) begin
          state_d = StScan;
        end
      end
      StScan: begin
        if (shift_en && idx_q == SlotW'(TimerSlots - 1)) begin
          state_d = StFinish;
        end
      end
      StFinish: begin
        if (advance) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Scan bookkeeping and response generation.
  always_comb begin
    idx_d        = idx_q;
    add_pend_d   = add_pend_q;
    found_d      = found_q;
    res_slot_d   = res_slot_q;
    hold_valid_d = hold_valid_q;
    hold_slot_d  = hold_slot_q;
    hold_tag_d   = hold_tag_q;
    cnt_d        = cnt_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_slot_d   = out_slot_q;
    out_tag_d    = out_tag_q;
    out_last_d   = out_last_q;

    // A taken response empties the output register.
    if (advance) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          idx_d        = '0;
          add_pend_d   = 1'b1;
          found_d      = 1'b0;
          hold_valid_d = 1'b0;
          cnt_d        = '0;
        end
      end
      StScan: begin
        if (shift_en) begin
          idx_d = idx_q + SlotW'(1);
          if (proc_stat.placed) begin
            add_pend_d = 1'b0;
            res_slot_d = idx_q;
          end
          if (proc_stat.deleted) begin
            found_d = 1'b1;
          end
          // A fired slot is held back one step so the final one can carry last.
          if (proc_stat.fired && cnt_q < CntW'(MaxResults)) begin
            cnt_d        = cnt_q + CntW'(1);
            hold_valid_d = 1'b1;
            hold_slot_d  = idx_q;
            hold_tag_d   = ring[0].tag;
            if (hold_valid_q) begin
              out_valid_d  = 1'b1;
              out_status_d = StatFired;
              out_slot_d   = SlotNumW'(hold_slot_q);
              out_tag_d    = hold_tag_q;
              out_last_d   = 1'b0;
            end
          end
        end
      end
      StFinish: begin
        if (advance) begin
          out_valid_d  = 1'b1;
          out_last_d   = 1'b1;
          out_tag_d    = '0;
          hold_valid_d = 1'b0;
          unique case (op_req_q)
            ReqAdd: begin
              if (add_pend_q) begin
                out_status_d = StatFull;
                out_slot_d   = '0;
              end else begin
                out_status_d = StatAdded;
                out_slot_d   = SlotNumW'(res_slot_q);
              end
            end
            ReqDelete: begin
              out_status_d = found_q ? StatDeleted : StatNotFound;
              out_slot_d   = op_target_q;
            end
            ReqTick: begin
              if (hold_valid_q) begin
                out_status_d = StatFired;
                out_slot_d   = SlotNumW'(hold_slot_q);
                out_tag_d    = hold_tag_q;
              end else begin
                out_status_d = StatNone;
                out_slot_d   = '0;
              end
            end
            default: begin
              out_status_d = StatNone;
              out_slot_d   = '0;
            end
          endcase
        end
      end
      default: begin
        idx_d = '0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      idx_q        <= '0;
      add_pend_q   <= 1'b0;
      found_q      <= 1'b0;
      hold_valid_q <= 1'b0;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      add_pend_q   <= add_pend_d;
      found_q      <= found_d;
      hold_valid_q <= hold_valid_d;
      cnt_q        <= cnt_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Request fields captured on transfer.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_req_q      <= req_e'(req_i.req_type);
      op_timeout_q  <= req_i.timeout_ticks;
      op_periodic_q <= req_i.periodic;
      op_tag_q      <= req_i.user_tag;
      op_target_q   <= req_i.target_slot;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    res_slot_q   <= res_slot_d;
    hold_slot_q  <= hold_slot_d;
    hold_tag_q   <= hold_tag_d;
    out_status_q <= out_status_d;
    out_slot_q   <= out_slot_d;
    out_tag_q    <= out_tag_d;
    out_last_q   <= out_last_d;
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_status_q;
  assign rsp_o.slot_number = out_slot_q;
  assign rsp_o.fired_tag   = out_tag_q;
  assign rsp_o.last_result = out_last_q;

`ifndef SYNTHESIS
  // A stalled response must freeze the ring position.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !rsp_o.ready) |=> $stable(idx_q))
    else $error("slot ring moved while the response was stalled");

  // A held fired slot only exists during a tick.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_valid_q |-> (op_req_q == ReqTick))
    else $error("fired slot held outside a tick");

  // Every scan starts at slot zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle && state_d == StScan) |=> (idx_q == '0))
    else $error("scan did not start at slot zero");

  // The reported fire count never passes its cap.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxResults))
    else $error("fire count exceeded the result cap");
`endif

endmodule

`default_nettype wire

/* test/tb_top.sv */
`default_nettype none

module tb_top;
  import mst_pkg::*;

  // Request code with no meaning; the block takes it and drops it.
  localparam logic [ReqW-1:0] ReqUndef = 2'd3;

  localparam int unsigned RandomItems = 280;
  localparam int unsigned MaxIdle     = 16;
  localparam int unsigned ItemCycles  = TimerSlots + 1;
  localparam int unsigned DrainCycles = 3 * ItemCycles;
  localparam int unsigned ReportLimit = 10;
  // Slowest run: every tick firing all slots, each response stalled to the limit.
  localparam int unsigned CycleLimit  =
    4 * (RandomItems + 25) * (MaxIdle + ItemCycles + MaxResults * (MaxIdle + ItemCycles));

  // One response as the block should present it.
  typedef struct packed {
    status_e             st;
    logic [SlotNumW-1:0] slot;
    logic [TagW-1:0]     ftag;
    logic                last;
  } timer_rsp_t;

  // One row of the directed stimulus, with an optional typed-in response.
  typedef struct packed {
    logic [ReqW-1:0]     kind;
    logic [TimeoutW-1:0] tmo;
    logic                per;
    logic [TagW-1:0]     tag;
    logic [SlotNumW-1:0] tgt;
    logic                chk;
    timer_rsp_t          rsp;
  } stim_row_t;

  localparam int unsigned DirRows = 25;
  localparam stim_row_t DirTable [DirRows] = '{
    '{ReqTick,   16'h1234, 1'b1, 8'hC6, 4'h9, 1'b1, '{StatNone,     4'd0,  8'h00, 1'b1}},
    '{ReqDelete, 16'hFFFF, 1'b1, 8'hFF, 4'h0, 1'b1, '{StatNotFound, 4'd0,  8'h00, 1'b1}},
    '{ReqUndef,  16'hFFFF, 1'b1, 8'hFF, 4'hF, 1'b0, '{StatNone,     4'd0,  8'h00, 1'b0}},
    '{ReqAdd,    16'h0000, 1'b0, 8'hFF, 4'hF, 1'b1, '{StatAdded,    4'd0,  8'h00, 1'b1}},
    '{ReqAdd,    16'h0000, 1'b1, 8'h00, 4'h0, 1'b1, '{StatAdded,    4'd1,  8'h00, 1'b1}},
    '{ReqAdd,    16'h0001, 1'b0, 8'hA5, 4'h5, 1'b1, '{StatAdded,    4'd2,  8'h00, 1'b1}},
    '{ReqAdd,    16'h0001, 1'b1, 8'h5A, 4'hA, 1'b1, '{StatAdded,    4'd3,  8'h00, 1'b1}},
    '{ReqAdd,    16'h0002, 1'b0, 8'h01, 4'h3, 1'b1, '{StatAdded,    4'd4,  8'h00, 1'b1}},
    '{ReqAdd,    16'h0002, 1'b1, 8'h80, 4'hC, 1'b1, '{StatAdded,    4'd5,  8'h00, 1'b1}},
    '{ReqAdd,    16'h0003, 1'b1, 8'h7F, 4'h6, 1'b1, '{StatAdded,    4'd6,  8'h00, 1'b1}},
    '{ReqAdd,    16'hFFFF, 1'b0, 8'h3C, 4'h9, 1'b1, '{StatAdded,    4'd7,  8'h00, 1'b1}},
    '{ReqAdd,    16'h8000, 1'b1, 8'hC3, 4'h1, 1'b1, '{StatAdded,    4'd8,  8'h00, 1'b1}},
    '{ReqAdd,    16'h0004, 1'b0, 8'h11, 4'h2, 1'b1, '{StatAdded,    4'd9,  8'h00, 1'b1}},
    '{ReqAdd,    16'h0005, 1'b1, 8'h22, 4'h4, 1'b1, '{StatAdded,    4'd10, 8'h00, 1'b1}},
    '{ReqAdd,    16'h0000, 1'b1, 8'h33, 4'h8, 1'b1, '{StatAdded,    4'd11, 8'h00, 1'b1}},
    '{ReqAdd,    16'h7FFF, 1'b0, 8'h44, 4'h7, 1'b1, '{StatAdded,    4'd12, 8'h00, 1'b1}},
    '{ReqAdd,    16'h0001, 1'b0, 8'h55, 4'hB, 1'b1, '{StatAdded,    4'd13, 8'h00, 1'b1}},
    '{ReqAdd,    16'h0006, 1'b1, 8'h66, 4'hD, 1'b1, '{StatAdded,    4'd14, 8'h00, 1'b1}},
    '{ReqAdd,    16'hFFFF, 1'b1, 8'h99, 4'hE, 1'b1, '{StatAdded,    4'd15, 8'h00, 1'b1}},
    '{ReqAdd,    16'h0010, 1'b1, 8'hEE, 4'h0, 1'b1, '{StatFull,     4'd0,  8'h00, 1'b1}},
    '{ReqTick,   16'h0000, 1'b0, 8'h00, 4'h0, 1'b0, '{StatNone,     4'd0,  8'h00, 1'b0}},
    '{ReqDelete, 16'h0000, 1'b0, 8'h00, 4'hF, 1'b1, '{StatDeleted,  4'd15, 8'h00, 1'b1}},
    '{ReqDelete, 16'h5555, 1'b1, 8'hAA, 4'hF, 1'b1, '{StatNotFound, 4'd15, 8'h00, 1'b1}},
    '{ReqTick,   16'hFFFF, 1'b1, 8'hFF, 4'hF, 1'b0, '{StatNone,     4'd0,  8'h00, 1'b0}},
    '{ReqTick,   16'hAAAA, 1'b0, 8'h55, 4'h5, 1'b0, '{StatNone,     4'd0,  8'h00, 1'b0}}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  mst_req_if req_bus ();
  mst_rsp_if rsp_bus ();

  multi_slot_software_timer DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus.sink),
    .rsp_o  (rsp_bus.source)
  );

  // Predicted copy of the timer table.
  logic                slot_busy   [TimerSlots];
  logic [TimeoutW-1:0] slot_limit  [TimerSlots];
  logic [TickBits-1:0] slot_count  [TimerSlots];
  logic                slot_reload [TimerSlots];
  logic [TagW-1:0]     slot_label  [TimerSlots];

  timer_rsp_t step_rsp_q [$];
  timer_rsp_t pending_rsp_q [$];

  // Typed-in response for the directed row now on the request channel.
  logic       typed_chk;
  timer_rsp_t typed_rsp;

  // Shared idling control and bookkeeping.
  bit          quiet;
  int unsigned rsp_count;
  int unsigned rsp_seen;
  int unsigned rsp_hold;
  int unsigned cycles;
  int unsigned fail_count;
  int unsigned n_add, n_del, n_tick, n_ignored;
  int unsigned n_fired, n_full, n_missing;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Apply one request to the predicted table and collect the responses it causes.
  task automatic advance_timer_table(input logic [ReqW-1:0] kind,
                                     input logic [TimeoutW-1:0] tmo,
                                     input logic per,
                                     input logic [TagW-1:0] tag,
                                     input logic [SlotNumW-1:0] tgt);
    int   s;
    int   fired;
    logic placed;
    step_rsp_q.delete();
    fired  = 0;
    placed = 1'b0;
    case (kind)
      ReqAdd: begin
        for (s = 0; s < TimerSlots; s++) begin
          if (!placed && !slot_busy[s]) begin
            placed         = 1'b1;
            slot_busy[s]   = 1'b1;
            slot_limit[s]  = tmo;
            slot_count[s]  = '0;
            slot_reload[s] = per;
            slot_label[s]  = tag;
            step_rsp_q.push_back('{StatAdded, s[SlotNumW-1:0], '0, 1'b1});
          end
        end
        if (!placed) step_rsp_q.push_back('{StatFull, '0, '0, 1'b1});
      end
      ReqDelete: begin
        if (int'(tgt) < TimerSlots && slot_busy[tgt]) begin
          slot_busy[tgt] = 1'b0;
          step_rsp_q.push_back('{StatDeleted, tgt, '0, 1'b1});
        end else begin
          step_rsp_q.push_back('{StatNotFound, tgt, '0, 1'b1});
        end
      end
      ReqTick: begin
        for (s = 0; s < TimerSlots; s++) begin
          if (slot_busy[s]) begin
            // The count saturates at its top value.
            if (slot_count[s] != '1) slot_count[s] = slot_count[s] + 1'b1;
            if (ElCmpW'(slot_count[s]) >= ElCmpW'(slot_limit[s])) begin
              if (fired < MaxResults) begin
                step_rsp_q.push_back('{StatFired, s[SlotNumW-1:0], slot_label[s], 1'b0});
                fired++;
              end
              if (slot_reload[s]) slot_count[s] = '0;
              else slot_busy[s] = 1'b0;
            end
          end
        end
        if (fired == 0) step_rsp_q.push_back('{StatNone, '0, '0, 1'b1});
        else step_rsp_q[step_rsp_q.size()-1].last = 1'b1;
      end
      default: begin
      end
    endcase
  endtask

  // Offer one request after a random gap and hold it until the transfer.
  task automatic offer_request(input logic [ReqW-1:0] kind,
                               input logic [TimeoutW-1:0] tmo,
                               input logic per,
                               input logic [TagW-1:0] tag,
                               input logic [SlotNumW-1:0] tgt,
                               input logic chk,
                               input timer_rsp_t rsp);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, MaxIdle);
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_bus.valid         <= 1'b1;
    req_bus.req_type      <= kind;
    req_bus.timeout_ticks <= tmo;
    req_bus.periodic      <= per;
    req_bus.user_tag      <= tag;
    req_bus.target_slot   <= tgt;
    typed_chk             <= chk;
    typed_rsp             <= rsp;
    do @(posedge clk_i); while (!(req_bus.valid && req_bus.ready));
    @(negedge clk_i);
  endtask

  // Request monitor, predictor hookup, response checker and watchdog.
  always @(posedge clk_i) begin
    timer_rsp_t want;
    timer_rsp_t got;
    if (rst_ni) begin
      cycles++;
      if (cycles > CycleLimit) begin
        $display("timeout after %0d cycles, %0d responses outstanding",
                 cycles, pending_rsp_q.size());
        $display("tb_top: FAIL");
        $finish;
      end

      if (req_bus.valid && req_bus.ready) begin
        advance_timer_table(req_bus.req_type, req_bus.timeout_ticks, req_bus.periodic,
                            req_bus.user_tag, req_bus.target_slot);
        case (req_bus.req_type)
          ReqAdd:    n_add++;
          ReqDelete: n_del++;
          ReqTick:   n_tick++;
          default:   n_ignored++;
        endcase
        if (typed_chk) pending_rsp_q.push_back(typed_rsp);
        else foreach (step_rsp_q[k]) pending_rsp_q.push_back(step_rsp_q[k]);
      end

      if (rsp_bus.valid && rsp_bus.ready) begin
        rsp_count++;
        got = '{status_e'(rsp_bus.status), rsp_bus.slot_number, rsp_bus.fired_tag,
                rsp_bus.last_result};
        case (got.st)
          StatFired:    n_fired++;
          StatFull:     n_full++;
          StatNotFound: n_missing++;
          default: begin
          end
        endcase
        if (pending_rsp_q.size() == 0) begin
          fail_count++;
          if (fail_count <= ReportLimit)
            $display("unexpected response: status %0d slot %0d tag %02h last %0b",
                     got.st, got.slot, got.ftag, got.last);
        end else begin
          want = pending_rsp_q.pop_front();
          if (got.st !== want.st || got.slot !== want.slot || got.ftag !== want.ftag ||
              got.last !== want.last) begin
            fail_count++;
            if (fail_count <= ReportLimit)
              $display("response mismatch: got status %0d slot %0d tag %02h last %0b, %s",
                       got.st, got.slot, got.ftag, got.last,
                       $sformatf("wanted status %0d slot %0d tag %02h last %0b",
                                 want.st, want.slot, want.ftag, want.last));
          end
        end
      end
    end
  end

  // Response side: stall a random number of cycles after each transfer.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (rsp_seen != rsp_count) begin
        rsp_seen = rsp_count;
        rsp_hold = quiet ? 0 : $urandom_range(0, MaxIdle);
      end
      if (rsp_hold > 0) begin
        rsp_bus.ready <= 1'b0;
        rsp_hold--;
      end else begin
        rsp_bus.ready <= 1'b1;
      end
    end else begin
      rsp_bus.ready <= 1'b0;
    end
  end

  // Stimulus: directed table, then random traffic in fill, mixed and drain phases.
  initial begin
    int unsigned         row;
    int unsigned         sent;
    int unsigned         pick;
    int unsigned         phase;
    logic [ReqW-1:0]     kind;
    logic [TimeoutW-1:0] tmo;
    timer_rsp_t          none_rsp;

    rst_ni                = 1'b0;
    req_bus.valid         = 1'b0;
    req_bus.req_type      = ReqAdd;
    req_bus.timeout_ticks = '0;
    req_bus.periodic      = 1'b0;
    req_bus.user_tag      = '0;
    req_bus.target_slot   = '0;
    typed_chk             = 1'b0;
    typed_rsp             = '0;
    quiet                 = 1'b0;
    none_rsp              = '0;
    foreach (slot_busy[s]) slot_busy[s] = 1'b0;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (row = 0; row < DirRows; row++) begin
      offer_request(DirTable[row].kind, DirTable[row].tmo, DirTable[row].per,
                    DirTable[row].tag, DirTable[row].tgt, DirTable[row].chk,
                    DirTable[row].rsp);
    end

    sent = 0;
    while (sent < RandomItems) begin
      quiet = ((sent / 50) % 4) == 3;
      phase = (sent / 40) % 3;
      pick  = $urandom_range(0, 99);
      case (phase)
        0:       kind = (pick < 60) ? ReqAdd : (pick < 75) ? ReqDelete :
                        (pick < 97) ? ReqTick : ReqUndef;
        1:       kind = (pick < 35) ? ReqAdd : (pick < 60) ? ReqDelete :
                        (pick < 95) ? ReqTick : ReqUndef;
        default: kind = (pick < 15) ? ReqAdd : (pick < 45) ? ReqDelete :
                        (pick < 97) ? ReqTick : ReqUndef;
      endcase
      // Mostly short timeouts so that timers fire; now and then any value.
      pick = $urandom_range(0, 9);
      if (pick < 6)      tmo = TimeoutW'($urandom_range(0, 6));
      else if (pick < 8) tmo = TimeoutW'($urandom_range(0, 40));
      else if (pick < 9) tmo = TimeoutW'($urandom);
      else               tmo = '1;

      // At the halfway point, hold the request side until every response has come back.
      if (sent == RandomItems / 2) begin
        req_bus.valid <= 1'b0;
        while (pending_rsp_q.size() != 0) @(posedge clk_i);
        @(negedge clk_i);
      end

      offer_request(kind, tmo, 1'($urandom), TagW'($urandom), SlotNumW'($urandom),
                    1'b0, none_rsp);
      if (kind != ReqUndef) sent++;
    end

    req_bus.valid <= 1'b0;
    quiet = 1'b0;
    while (pending_rsp_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("summary: %0d adds, %0d deletes, %0d ticks, %0d undefined requests taken",
             n_add, n_del, n_tick, n_ignored);
    $display("summary: %0d timer firings, %0d table-full and %0d not-found responses",
             n_fired, n_full, n_missing);
    if (fail_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("%0d response errors", fail_count);
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* sim.f */
hw/rtl/mst_pkg.sv
hw/rtl/mst_req_if.sv
hw/rtl/mst_rsp_if.sv
hw/rtl/mst_cell.sv
hw/rtl/mst_slot_proc.sv
hw/rtl/multi_slot_software_timer.sv
test/tb_top.sv
